// ===== sv/pvs_pkg.sv =====
// Shared types, widths and helpers for the path via-point selector.
// Holds the pose and result structs, the segment class codes, the
// configuration register indexes and the squared-distance function.
package pvs_pkg;

  // Field widths
  localparam int POS_WIDTH   = 20;
  localparam int ANGLE_WIDTH = 16;

  // Configuration register widths
  localparam int TRANS_W = 16;
  localparam int ROT_W   = 15;
  localparam int SEP_W   = 16;
  localparam int LOOK_W  = 19;
  localparam int CFG_W   = (POS_WIDTH > LOOK_W) ? POS_WIDTH : LOOK_W;
  localparam int CFG_IDX_W = 3;

  // Squared distance width and compare widths
  localparam int DIST_W    = 2 * POS_WIDTH + 2;
  localparam int CMP_W     = (DIST_W > 2 * LOOK_W) ? DIST_W : 2 * LOOK_W;
  localparam int ROT_CMP_W = (ANGLE_WIDTH > ROT_W) ? ANGLE_WIDTH : ROT_W;

  // Stream word widths; the data words are padded to whole bytes
  localparam int POSE_W     = 2 * POS_WIDTH + ANGLE_WIDTH;
  localparam int IN_DATA_W  = ((POSE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((POSE_W + 7) / 8) * 8;
  localparam int OUT_USER_W = 3;

  // Register reset values, kept squared where the compare needs a square
  localparam logic [2*TRANS_W-1:0] TRANS_SQ_RST = (2*TRANS_W)'(100);
  localparam logic [ROT_W-1:0]     ROT_THR_RST  = ROT_W'(104);
  localparam logic [2*SEP_W-1:0]   SEP_SQ_RST   = (2*SEP_W)'(250000);
  localparam logic [2*LOOK_W-1:0]  LOOK_SQ_RST  = (2*LOOK_W)'(6250000);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_THR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROT_THR   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SEP   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_ROBOT_X   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_ROBOT_Y   = CFG_IDX_W'(5);

  typedef enum logic [1:0] {
    CLS_UNDEF = 2'd0,
    CLS_TRANS = 2'd1,
    CLS_ROT   = 2'd2,
    CLS_ARC   = 2'd3
  } seg_class_t;

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] heading;
    logic signed [POS_WIDTH-1:0]   y;
    logic signed [POS_WIDTH-1:0]   x;
  } pose_t;

  typedef struct packed {
    logic       done;
    pose_t      pose;
    seg_class_t cls;
    logic       viapoint;
  } result_t;

  // Squared Euclidean distance between two points
  function automatic logic [DIST_W-1:0] dist2(
    input logic signed [POS_WIDTH-1:0] ax,
    input logic signed [POS_WIDTH-1:0] ay,
    input logic signed [POS_WIDTH-1:0] bx,
    input logic signed [POS_WIDTH-1:0] by
  );
    logic [POS_WIDTH:0] dx;
    logic [POS_WIDTH:0] dy;
    logic [POS_WIDTH:0] mx;
    logic [POS_WIDTH:0] my;
    logic [DIST_W-1:0]  sx;
    logic [DIST_W-1:0]  sy;
    dx = {bx[POS_WIDTH-1], bx} - {ax[POS_WIDTH-1], ax};
    dy = {by[POS_WIDTH-1], by} - {ay[POS_WIDTH-1], ay};
    mx = dx[POS_WIDTH] ? (~dx + 1'b1) : dx;
    my = dy[POS_WIDTH] ? (~dy + 1'b1) : dy;
    sx = DIST_W'(mx) * DIST_W'(mx);
    sy = DIST_W'(my) * DIST_W'(my);
    return sx + sy;
  endfunction

endpackage

// ===== sv/path_viapoint_selector.sv =====
// Path via-point selector: classifies each path segment and picks via-points.
// Depends on pvs_pkg for types, widths, register indexes and dist2().
//
// An accepted input word passes the input register, then the result
// register. Throughput: one word per cycle unless out_tready stalls the
// result stream; segment class, distances and the via-point decision
// are settled in the single stage between the registers.
// Reset (rst_n low, synchronous): pipeline empty, pose state cleared,
// registers back to their defaults; no clearing pass is needed.
module path_viapoint_selector (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pvs_pkg::IN_DATA_W-1:0]     in_tdata,  // pos_x, pos_y, heading
  input  logic                              in_tuser,  // path_start
  input  logic                              in_tlast,  // path_end
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pvs_pkg::OUT_DATA_W-1:0]    out_tdata, // out_x, out_y, out_heading
  output logic [pvs_pkg::OUT_USER_W-1:0]    out_tuser, // viapoint_valid, segment_class
  output logic                              out_tlast, // path_done
  // Configuration write port
  input  logic                              cfg_we,
  input  logic [pvs_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [pvs_pkg::CFG_W-1:0]         cfg_wdata
);
  import pvs_pkg::*;

  // Configuration registers (translation, separation and lookahead thresholds kept squared)
  logic [2*TRANS_W-1:0]          trans_sq_r;
  logic [ROT_W-1:0]              rot_thr_r;
  logic [2*SEP_W-1:0]            sep_sq_r;
  logic [2*LOOK_W-1:0]           look_sq_r;
  logic signed [POS_WIDTH-1:0]   robot_x_r;
  logic signed [POS_WIDTH-1:0]   robot_y_r;

  // Input register
  logic                          s1_valid_r;
  pose_t                         s1_pose_r;
  logic                          s1_start_r;
  logic                          s1_last_r;

  // Result register
  logic                          res_valid_r;
  result_t                       res_r;

  // Path state
  pose_t                         prev_r;
  seg_class_t                    prev_cls_r;
  logic signed [POS_WIDTH-1:0]   via_x_r;
  logic signed [POS_WIDTH-1:0]   via_y_r;
  logic                          have_prev_r;

  // Stage logic
  logic                          adv2;
  logic                          prime;
  logic [DIST_W-1:0]             seg_d2;
  logic [DIST_W-1:0]             robot_d2;
  logic [DIST_W-1:0]             via_d2;
  logic [ANGLE_WIDTH-1:0]        dh;
  logic [ANGLE_WIDTH-1:0]        dh_mag;
  logic                          is_t;
  logic                          is_r;
  logic                          in_look;
  logic                          sep_hit;
  seg_class_t                    cls;
  logic                          vp_nxt;
  result_t                       res_nxt;
  pose_t                         in_pose;

  // Unpack the input word
  assign in_pose.x       = in_tdata[POS_WIDTH-1:0];
  assign in_pose.y       = in_tdata[2*POS_WIDTH-1:POS_WIDTH];
  assign in_pose.heading = in_tdata[POSE_W-1:2*POS_WIDTH];

  // Handshake: the input register moves whenever the result register frees up
  assign adv2      = s1_valid_r && (!res_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv2;

  // Classify the segment and decide on the pending pose
  always_comb begin
    prime    = s1_start_r || !have_prev_r;
    seg_d2   = dist2(prev_r.x, prev_r.y, s1_pose_r.x, s1_pose_r.y);
    robot_d2 = dist2(robot_x_r, robot_y_r, prev_r.x, prev_r.y);
    via_d2   = dist2(via_x_r, via_y_r, prev_r.x, prev_r.y);
    dh       = s1_pose_r.heading - prev_r.heading;
    dh_mag   = dh[ANGLE_WIDTH-1] ? (~dh + 1'b1) : dh;
    is_t     = CMP_W'(seg_d2) > CMP_W'(trans_sq_r);
    is_r     = ROT_CMP_W'(dh_mag) > ROT_CMP_W'(rot_thr_r);
    in_look  = CMP_W'(robot_d2) < CMP_W'(look_sq_r);
    sep_hit  = CMP_W'(via_d2) >= CMP_W'(sep_sq_r);
    cls      = seg_class_t'({is_r, is_t});
    vp_nxt   = !prime && in_look &&
               ((cls != prev_cls_r) || (cls == CLS_ROT) || sep_hit);

    res_nxt.viapoint = vp_nxt;
    res_nxt.done     = s1_last_r;
    if (prime) begin
      res_nxt.cls  = CLS_UNDEF;
      res_nxt.pose = '0;
    end else begin
      res_nxt.cls  = cls;
      res_nxt.pose = prev_r;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_sq_r <= TRANS_SQ_RST;
      rot_thr_r  <= ROT_THR_RST;
      sep_sq_r   <= SEP_SQ_RST;
      look_sq_r  <= LOOK_SQ_RST;
      robot_x_r  <= '0;
      robot_y_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TRANS_THR: trans_sq_r <= (2*TRANS_W)'(cfg_wdata[TRANS_W-1:0]) *
                                     (2*TRANS_W)'(cfg_wdata[TRANS_W-1:0]);
        REG_ROT_THR:   rot_thr_r  <= cfg_wdata[ROT_W-1:0];
        REG_MAX_SEP:   sep_sq_r   <= (2*SEP_W)'(cfg_wdata[SEP_W-1:0]) *
                                     (2*SEP_W)'(cfg_wdata[SEP_W-1:0]);
        REG_LOOKAHEAD: look_sq_r  <= (2*LOOK_W)'(cfg_wdata[LOOK_W-1:0]) *
                                     (2*LOOK_W)'(cfg_wdata[LOOK_W-1:0]);
        REG_ROBOT_X:   robot_x_r  <= cfg_wdata[POS_WIDTH-1:0];
        REG_ROBOT_Y:   robot_y_r  <= cfg_wdata[POS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_pose_r  <= in_pose;
      s1_start_r <= in_tuser;
      s1_last_r  <= in_tlast;
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (adv2) begin
      res_valid_r <= 1'b1;
    end else if (out_tready) begin
      res_valid_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (adv2) begin
      res_r <= res_nxt;
    end
  end

  // Advance the path state as each word leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      prev_cls_r  <= CLS_UNDEF;
      via_x_r     <= '0;
      via_y_r     <= '0;
      have_prev_r <= 1'b0;
    end else if (adv2) begin
      prev_r      <= s1_pose_r;
      have_prev_r <= !s1_last_r;
      if (prime) begin
        prev_cls_r <= CLS_UNDEF;
        via_x_r    <= s1_pose_r.x;
        via_y_r    <= s1_pose_r.y;
      end else begin
        prev_cls_r <= cls;
        if (vp_nxt) begin
          via_x_r <= prev_r.x;
          via_y_r <= prev_r.y;
        end
      end
    end
  end

  // Drive the result stream
  assign out_tvalid = res_valid_r;
  assign out_tdata  = OUT_DATA_W'(res_r.pose);
  assign out_tuser  = {res_r.cls, res_r.viapoint};
  assign out_tlast  = res_r.done;

  // A priming word yields an empty result
  a_prime_empty: assert property (@(posedge clk) disable iff (!rst_n)
    adv2 && prime |=> !res_r.viapoint && res_r.cls == CLS_UNDEF && res_r.pose == '0)
    else $error("priming word produced a non-empty result");

  // The last word of a path closes it
  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    adv2 && s1_last_r |=> !have_prev_r)
    else $error("path still open after its last word");

  // The via-point moves only on an emitted via-point or a priming word
  a_via_hold: assert property (@(posedge clk) disable iff (!rst_n)
    adv2 && !prime && !vp_nxt |=> $stable(via_x_r) && $stable(via_y_r))
    else $error("via-point moved without an emit");

  // No via-point outside the lookahead
  a_lookahead: assert property (@(posedge clk) disable iff (!rst_n)
    adv2 && !in_look |=> !res_r.viapoint)
    else $error("via-point emitted outside the lookahead");

endmodule
